// File: rtl/aegc_pkg.sv
// shared types and constants for the accept-encoding gzip checker
// no dependencies; imported by every module of the block
`default_nettype none

package aegc_pkg;

    // depth of the queue between the classifier and the parser
    localparam int AEGC_QDEPTH = 4;
    localparam int AEGC_QPTR_W = (AEGC_QDEPTH > 1) ? $clog2(AEGC_QDEPTH) : 1;
    localparam int AEGC_QCNT_W = $clog2(AEGC_QDEPTH + 1);

    // one header byte after classification
    typedef struct packed {
        logic has_char;
        logic last;
        logic is_nul;
        logic is_comma;
        logic is_semi;
        logic is_ws;
        logic is_q;
        logic is_eq;
        logic is_zero;
        logic is_dot;
        // letters of the three tokens, compared after lower-casing
        logic ch_g;
        logic ch_z;
        logic ch_i;
        logic ch_p;
        logic ch_x;
        logic ch_dash;
        logic ch_star;
    } aegc_item_t;

endpackage

`default_nettype wire

// File: rtl/aegc_classify.sv
// front end: takes header bytes from the input stream and classifies them
// depends on aegc_pkg
`default_nettype none

module aegc_classify import aegc_pkg::*; (
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // char_byte
    input  wire logic       s_tuser,   // has_char
    input  wire logic       s_tlast,   // last
    input  wire logic       q_ready,
    output logic            q_push,
    output aegc_item_t      q_item
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Z     = 8'h7a;

    logic [7:0] lc;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        lc = s_tdata;
        if (s_tdata >= CH_UP_A && s_tdata <= CH_UP_Z) begin
            lc = s_tdata | CH_CASE;
        end
    end

    always_comb begin
        q_item          = '0;
        q_item.has_char = s_tuser;
        q_item.last     = s_tlast;
        q_item.is_nul   = (s_tdata == CH_NUL);
        q_item.is_comma = (s_tdata == CH_COMMA);
        q_item.is_semi  = (s_tdata == CH_SEMI);
        q_item.is_ws    = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        q_item.is_q     = (lc == CH_Q);
        q_item.is_eq    = (s_tdata == CH_EQ);
        q_item.is_zero  = (s_tdata == CH_ZERO);
        q_item.is_dot   = (s_tdata == CH_DOT);
        q_item.ch_g     = (lc == CH_G);
        q_item.ch_z     = (lc == CH_Z);
        q_item.ch_i     = (lc == CH_I);
        q_item.ch_p     = (lc == CH_P);
        q_item.ch_x     = (lc == CH_X);
        q_item.ch_dash  = (s_tdata == CH_DASH);
        q_item.ch_star  = (s_tdata == CH_STAR);
    end

endmodule

`default_nettype wire

// File: rtl/aegc_queue.sv
// short register queue carrying classified bytes from front end to parser
// depends on aegc_pkg
`default_nettype none

module aegc_queue import aegc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire aegc_item_t  push_item,
    output logic             push_ready,
    input  wire logic        pop,
    output logic             pop_valid,
    output aegc_item_t       pop_item
);

    aegc_item_t             slot_reg [AEGC_QDEPTH];
    logic [AEGC_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AEGC_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AEGC_QCNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != AEGC_QCNT_W'(AEGC_QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AEGC_QPTR_W'(AEGC_QDEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AEGC_QPTR_W'(AEGC_QDEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/aegc_parse.sv
// back end: element and parameter parser, verdict tracking, result register
// depends on aegc_pkg
`default_nettype none

module aegc_parse import aegc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire aegc_item_t  q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // accepts_gzip, bits 7:1 zero
);

    typedef enum logic [3:0] {
        EL_LEAD   = 4'b0001,
        EL_TOKEN  = 4'b0010,
        EL_TRAIL  = 4'b0100,
        EL_PARAMS = 4'b1000
    } el_phase_t;

    typedef enum logic [6:0] {
        PP_LEAD   = 7'b0000001,
        PP_SKIP   = 7'b0000010,
        PP_Q      = 7'b0000100,
        PP_V0     = 7'b0001000,
        PP_VREST  = 7'b0010000,
        PP_VTRAIL = 7'b0100000,
        PP_DONE   = 7'b1000000
    } pp_phase_t;

    localparam logic [1:0] QV_UNDECIDED = 2'd0;
    localparam logic [1:0] QV_ZERO      = 2'd1;
    localparam logic [1:0] QV_NONZERO   = 2'd2;

    localparam logic [1:0] VD_NONE   = 2'd0;
    localparam logic [1:0] VD_REFUSE = 2'd1;
    localparam logic [1:0] VD_ACCEPT = 2'd2;

    localparam logic [2:0] LEN_GZIP  = 3'd4;
    localparam logic [2:0] LEN_XGZIP = 3'd6;
    localparam logic [2:0] LEN_STAR  = 3'd1;
    localparam logic [2:0] POS_MAX   = 3'd7;

    typedef struct packed {
        logic [1:0] gz;
        logic [1:0] st;
    } verd_pair_t;

    el_phase_t  el_reg,    el_next;
    pp_phase_t  pp_reg,    pp_next;
    logic [1:0] qv_reg,    qv_next;
    logic [2:0] pos_reg,   pos_next;
    logic [2:0] cand_reg,  cand_next;
    logic [1:0] gz_reg,    gz_next;
    logic [1:0] st_reg,    st_next;
    logic       ended_reg, ended_next;
    logic       mvalid_reg, mvalid_next;
    logic       acc_reg,   acc_next;

    // verdicts after closing the element in progress
    function automatic verd_pair_t close_elem(
        el_phase_t  ep,
        pp_phase_t  pp,
        logic [1:0] qv,
        logic [2:0] pos,
        logic [2:0] cand,
        logic [1:0] gz,
        logic [1:0] st
    );
        logic [1:0] q;
        logic       zero;
        verd_pair_t r;
        q = qv;
        if (pp == PP_V0) begin
            q = QV_NONZERO;
        end else if (pp == PP_VREST || pp == PP_VTRAIL) begin
            q = QV_ZERO;
        end
        zero = (ep == EL_PARAMS) && (q == QV_ZERO);
        r.gz = gz;
        r.st = st;
        if ((cand[0] && pos == LEN_GZIP) || (cand[1] && pos == LEN_XGZIP)) begin
            r.gz = zero ? VD_REFUSE : VD_ACCEPT;
        end else if (cand[2] && pos == LEN_STAR) begin
            r.st = zero ? VD_REFUSE : VD_ACCEPT;
        end
        return r;
    endfunction

    verd_pair_t vp;
    logic       ok_gzip, ok_xgzip, ok_star;
    logic       pop;

    // a final byte needs the result slot free or draining this cycle
    assign pop   = q_valid && (!q_item.last || !mvalid_reg || m_tready);
    assign q_pop = pop;

    always_comb begin
        unique case (pos_reg)
            3'd0: begin
                ok_gzip  = q_item.ch_g;
                ok_xgzip = q_item.ch_x;
            end
            3'd1: begin
                ok_gzip  = q_item.ch_z;
                ok_xgzip = q_item.ch_dash;
            end
            3'd2: begin
                ok_gzip  = q_item.ch_i;
                ok_xgzip = q_item.ch_g;
            end
            3'd3: begin
                ok_gzip  = q_item.ch_p;
                ok_xgzip = q_item.ch_z;
            end
            3'd4: begin
                ok_gzip  = 1'b0;
                ok_xgzip = q_item.ch_i;
            end
            3'd5: begin
                ok_gzip  = 1'b0;
                ok_xgzip = q_item.ch_p;
            end
            default: begin
                ok_gzip  = 1'b0;
                ok_xgzip = 1'b0;
            end
        endcase
        ok_star = (pos_reg == '0) && q_item.ch_star;
    end

    always_comb begin
        el_next     = el_reg;
        pp_next     = pp_reg;
        qv_next     = qv_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        gz_next     = gz_reg;
        st_next     = st_reg;
        ended_next  = ended_reg;
        acc_next    = acc_reg;
        mvalid_next = mvalid_reg && !m_tready;
        vp          = '{gz: gz_reg, st: st_reg};

        if (pop) begin
            if (q_item.has_char && !ended_reg) begin
                if (q_item.is_nul || q_item.is_comma) begin
                    vp = close_elem(el_reg, pp_reg, qv_reg, pos_reg, cand_reg,
                                    gz_reg, st_reg);
                    gz_next    = vp.gz;
                    st_next    = vp.st;
                    el_next    = EL_LEAD;
                    pp_next    = PP_LEAD;
                    qv_next    = QV_UNDECIDED;
                    pos_next   = '0;
                    cand_next  = 3'b111;
                    ended_next = q_item.is_nul;
                end else if (el_reg == EL_PARAMS) begin
                    unique case (pp_reg)
                        PP_LEAD: begin
                            if (q_item.is_q) begin
                                pp_next = PP_Q;
                            end else if (!q_item.is_ws && !q_item.is_semi) begin
                                pp_next = PP_SKIP;
                            end
                        end
                        PP_SKIP: begin
                            if (q_item.is_semi) begin
                                pp_next = PP_LEAD;
                            end
                        end
                        PP_Q: begin
                            if (q_item.is_eq) begin
                                pp_next = PP_V0;
                            end else if (q_item.is_semi) begin
                                pp_next = PP_LEAD;
                            end else begin
                                pp_next = PP_SKIP;
                            end
                        end
                        PP_V0: begin
                            if (q_item.is_zero) begin
                                pp_next = PP_VREST;
                            end else begin
                                qv_next = QV_NONZERO;
                                pp_next = PP_DONE;
                            end
                        end
                        PP_VREST: begin
                            if (q_item.is_dot || q_item.is_zero) begin
                                pp_next = PP_VREST;
                            end else if (q_item.is_ws) begin
                                pp_next = PP_VTRAIL;
                            end else begin
                                qv_next = q_item.is_semi ? QV_ZERO : QV_NONZERO;
                                pp_next = PP_DONE;
                            end
                        end
                        PP_VTRAIL: begin
                            if (!q_item.is_ws) begin
                                qv_next = q_item.is_semi ? QV_ZERO : QV_NONZERO;
                                pp_next = PP_DONE;
                            end
                        end
                        PP_DONE: begin
                            pp_next = PP_DONE;
                        end
                        default: begin
                            pp_next = pp_reg;
                        end
                    endcase
                end else if (q_item.is_semi) begin
                    el_next = EL_PARAMS;
                end else if (q_item.is_ws) begin
                    if (el_reg == EL_TOKEN) begin
                        el_next = EL_TRAIL;
                    end
                end else begin
                    el_next   = EL_TOKEN;
                    // a second word after whitespace spoils the token
                    cand_next = (el_reg == EL_TRAIL) ? 3'b000
                              : cand_reg & {ok_star, ok_xgzip, ok_gzip};
                    if (pos_reg != POS_MAX) begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            if (q_item.last) begin
                vp = close_elem(el_next, pp_next, qv_next, pos_next, cand_next,
                                gz_next, st_next);
                acc_next    = (vp.gz != VD_NONE) ? (vp.gz == VD_ACCEPT)
                                                 : (vp.st == VD_ACCEPT);
                mvalid_next = 1'b1;
                el_next     = EL_LEAD;
                pp_next     = PP_LEAD;
                qv_next     = QV_UNDECIDED;
                pos_next    = '0;
                cand_next   = 3'b111;
                gz_next     = VD_NONE;
                st_next     = VD_NONE;
                ended_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            el_reg     <= EL_LEAD;
            pp_reg     <= PP_LEAD;
            qv_reg     <= QV_UNDECIDED;
            pos_reg    <= '0;
            cand_reg   <= 3'b111;
            gz_reg     <= VD_NONE;
            st_reg     <= VD_NONE;
            ended_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            el_reg     <= el_next;
            pp_reg     <= pp_next;
            qv_reg     <= qv_next;
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            gz_reg     <= gz_next;
            st_reg     <= st_next;
            ended_reg  <= ended_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'b0, acc_reg};

endmodule

`default_nettype wire

// File: rtl/accept_encoding_gzip_check.sv
// top level of the accept-encoding gzip checker
// depends on aegc_pkg, aegc_classify, aegc_queue and aegc_parse
//
//  channel  | direction | tdata             | tuser    | tlast
//  ---------+-----------+-------------------+----------+------------
//  s_       | in        | [7:0] char_byte   | has_char | end of header
//  m_       | out       | [0] accepts_gzip  | -        | -
//
// one header byte is taken per cycle while the queue has room; the classifier is
// combinational, so a byte enters the queue at its accepting edge and the parser
// consumes it at the next edge at the earliest, loading the verdict register there;
// m_tvalid rises as the parser consumes the final byte. reset (aresetn low,
// synchronous) empties the queue and returns the parser to the start of a header.
// a final byte waits at the head of the queue while the previous verdict is not yet
// taken, holding the bytes behind it; the input stalls once the four-entry queue fills.
`default_nettype none

module accept_encoding_gzip_check import aegc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // char_byte
    input  wire logic       s_tuser,   // has_char
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // accepts_gzip, bits 7:1 zero
);

    aegc_item_t push_item, pop_item;
    logic       push, push_ready, pop, pop_valid;

    aegc_classify u_classify (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_ready  (push_ready),
        .q_push   (push),
        .q_item   (push_item)
    );

    aegc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    aegc_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
